/* hw/rtl/fqps_pkg.sv */
package fqps_pkg;

    localparam int FLOWS    = 16;
    localparam int FIDX_W   = $clog2(FLOWS);
    localparam int FCNT_W   = $clog2(FLOWS + 1);
    localparam int SLOTS    = 64;
    localparam int SIDX_W   = $clog2(SLOTS);
    localparam int QCNT_W   = 7;
    localparam int WALK_W   = $clog2(SLOTS + 1);
    localparam int RATE_W   = 30;
    localparam int NUM_W    = 43;
    localparam int PROD_W   = 22;
    localparam int TIME_W   = 48;
    localparam int DEF_W    = 18;
    localparam int SCALE_W  = 23;

    localparam logic [SCALE_W-1:0] BIT_SCALE  = SCALE_W'(8000000);
    localparam logic [15:0]        MIN_QUANT  = 16'd32;
    localparam logic [15:0]        DFLT_QUANT = 16'd2048;

    localparam logic [1:0] MODE_FIFO = 2'd0;
    localparam logic [1:0] MODE_WFQ  = 2'd1;
    localparam logic [1:0] MODE_DRR  = 2'd2;
    localparam logic [1:0] MODE_FIFO_ALT = 2'd3;

    localparam logic [2:0] RES_NONE = 3'd0;
    localparam logic [2:0] RES_ACC  = 3'd1;
    localparam logic [2:0] RES_FWD  = 3'd2;
    localparam logic [2:0] RES_DROP = 3'd3;
    localparam logic [2:0] RES_FULL = 3'd4;

    localparam logic [2:0] CFG_MODE    = 3'd0;
    localparam logic [2:0] CFG_QUANTUM = 3'd1;
    localparam logic [2:0] CFG_LIMIT   = 3'd2;
    localparam logic [2:0] CFG_DROPHD  = 3'd3;
    localparam logic [2:0] CFG_RATE    = 3'd4;
    localparam logic [2:0] CFG_OVH     = 3'd5;

    localparam logic KIND_ARRIVAL = 1'b0;

    typedef struct packed {
        logic        kind;
        logic [15:0] pkt_tag;
        logic [15:0] pkt_len;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic        ipv4_plain;
        logic [47:0] now_us;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [15:0] out_tag;
        logic [15:0] out_len;
        logic [31:0] flow_sig;
        logic [6:0]  queued_total;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [RATE_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } t_div_rsp;

    typedef logic [FLOWS-1:0][FIDX_W-1:0] t_ord;

    function automatic logic [31:0] flow_hash(logic [31:0] s, logic [31:0] d);
        logic [63:0] h;
        h = {32'd0, s} ^ ({32'd0, s} << 13) ^ ({32'd0, d} << 7) ^ ({32'd0, d} << 19);
        return h[31:0] ^ h[63:32];
    endfunction

    function automatic t_ord ord_insert(t_ord o, logic [FCNT_W-1:0] pos,
                                        logic [FIDX_W-1:0] f);
        t_ord r;
        r = o;
        for (int k = 1; k < FLOWS; k++) begin
            if (FCNT_W'(k) > pos) begin
                r[k] = o[k-1];
            end
        end
        r[pos[FIDX_W-1:0]] = f;
        return r;
    endfunction

    function automatic t_ord ord_remove(t_ord o, logic [FCNT_W-1:0] pos);
        t_ord r;
        r = o;
        for (int k = 0; k < FLOWS - 1; k++) begin
            if (FCNT_W'(k) >= pos) begin
                r[k] = o[k+1];
            end
        end
        return r;
    endfunction

    // Moves the front flow behind the other n-1 active flows.
    function automatic t_ord ord_rotate(t_ord o, logic [FCNT_W-1:0] n);
        t_ord r;
        r = o;
        for (int k = 0; k < FLOWS - 1; k++) begin
            if (FCNT_W'(k + 1) < n) begin
                r[k] = o[k+1];
            end
        end
        r[FIDX_W'(n - FCNT_W'(1))] = o[0];
        return r;
    endfunction

endpackage

/* hw/rtl/fqps_in_if.sv */
interface fqps_in_if;
    logic               valid;
    logic               ready;
    fqps_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/fqps_out_if.sv */
interface fqps_out_if;
    logic                valid;
    logic                ready;
    fqps_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/fqps_ram.sv */
module fqps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/fqps_div.sv */
module fqps_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fqps_pkg::t_div_req i_req,
    output fqps_pkg::t_div_rsp o_rsp
);
    import fqps_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_done, n_done;
    logic [RATE_W-1:0] r_rem, n_rem;
    logic [RATE_W-1:0] r_den, n_den;
    logic [NUM_W-1:0]  r_quo, n_quo;
    logic [RATE_W:0]   trial;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        trial  = {r_rem, r_quo[NUM_W-1]};
        if (i_req.start) begin
            n_cnt = CNT_W'(NUM_W);
            n_rem = '0;
            n_den = i_req.den;
            n_quo = i_req.num;
        end else if (r_cnt != '0) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = RATE_W'(trial - {1'b0, r_den});
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[RATE_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

/* hw/rtl/flow_queue_packet_scheduler.sv */
// Channel   Dir  Beat contents
// i_in      in   kind, pkt_tag, pkt_len, src_addr, dst_addr, ipv4_plain, now_us
// o_out     out  result_kind, out_tag, out_len, flow_sig, queued_total
// i_cfg_*   in   register index and write data, one write per enabled cycle
//
// One beat is taken at a time and yields exactly one result beat. An arrival scans
// the F active flows and, for a new flow, also searches up to 16 flow slots. WFQ
// placement adds the multiply, the shared divider and the sorted insert. A drop over
// the limit adds scans over the active flows plus up to 64 list-walk steps. A service
// reads the head packet (none with nothing queued), re-reading it per DRR rotation
// and adding, in WFQ mode, the placement of a flow that stays active.
// Reset is synchronous and clears all flows; the store needs no clearing.
// A pending result in the output register does not stop the next beat from entering.
module flow_queue_packet_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fqps_in_if.sink     i_in,
    fqps_out_if.source  o_out,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [29:0] i_cfg_wdata
);
    import fqps_pkg::*;

    typedef enum logic [21:0] {
        S_IDLE  = 22'h000001,
        S_LOOK  = 22'h000002,
        S_FREEF = 22'h000004,
        S_ALLOC = 22'h000008,
        S_POPW  = 22'h000010,
        S_WRPKT = 22'h000020,
        S_PLACE = 22'h000040,
        S_MUL1  = 22'h000080,
        S_MUL2  = 22'h000100,
        S_DIVW  = 22'h000200,
        S_FIN   = 22'h000400,
        S_INS   = 22'h000800,
        S_CHK   = 22'h001000,
        S_LONG  = 22'h002000,
        S_DHEAD = 22'h004000,
        S_WALK  = 22'h008000,
        S_DROP  = 22'h010000,
        S_FIND  = 22'h020000,
        S_SV0   = 22'h040000,
        S_SV1   = 22'h080000,
        S_SV3   = 22'h100000,
        S_EMIT  = 22'h200000
    } t_state;

    typedef logic [FLOWS-1:0][31:0]       t_sig_arr;
    typedef logic [FLOWS-1:0][QCNT_W-1:0] t_cnt_arr;
    typedef logic [FLOWS-1:0][DEF_W-1:0]  t_def_arr;
    typedef logic [FLOWS-1:0][TIME_W-1:0] t_fin_arr;
    typedef logic [FLOWS-1:0][SIDX_W-1:0] t_ptr_arr;

    // configuration
    logic [1:0]        r_mode;
    logic [15:0]       r_quantum;
    logic [5:0]        r_limit;
    logic              r_drop_head;
    logic [RATE_W-1:0] r_rate;
    logic [7:0]        r_ovh;

    // control state
    t_state            r_state, n_state;
    logic [FCNT_W-1:0] r_nact, n_nact;
    logic [QCNT_W-1:0] r_total, n_total;
    logic [QCNT_W-1:0] r_stk, n_stk;
    logic [QCNT_W-1:0] r_fresh, n_fresh;
    t_cnt_arr          r_cnt, n_cnt;
    logic              r_ovalid, n_ovalid;

    // payload state
    t_sig_arr          r_sig, n_sig;
    t_def_arr          r_def, n_def;
    t_fin_arr          r_fin, n_fin;
    t_ptr_arr          r_head, n_head;
    t_ptr_arr          r_tail, n_tail;
    t_ord              r_ord, n_ord;
    t_out_item         r_out, n_out;
    t_out_item         r_res, n_res;
    logic [15:0]       r_tag, n_tag;
    logic [15:0]       r_len, n_len;
    logic [31:0]       r_isig, n_isig;
    logic [TIME_W-1:0] r_now, n_now;
    logic              r_svc, n_svc;
    logic              r_found, n_found;
    logic [FCNT_W-1:0] r_pos, n_pos;
    logic [FIDX_W-1:0] r_fi, n_fi;
    logic [FIDX_W-1:0] r_f, n_f;
    logic [FIDX_W-1:0] r_g, n_g;
    logic [QCNT_W-1:0] r_longest, n_longest;
    logic [SIDX_W-1:0] r_p, n_p;
    logic [SIDX_W-1:0] r_q, n_q;
    logic [SIDX_W-1:0] r_d, n_d;
    logic [WALK_W-1:0] r_walk, n_walk;
    logic [15:0]       r_plen, n_plen;
    logic [PROD_W-1:0] r_prod, n_prod;

    // memories
    logic              pkt_we, nxt_we, fl_we;
    logic [SIDX_W-1:0] pkt_raddr, nxt_raddr, nxt_waddr, fl_raddr, nxt_wdata, fl_wdata;
    logic [31:0]       pkt_rdata;
    logic [SIDX_W-1:0] nxt_rdata, fl_rdata;

    t_div_req          div_req;
    t_div_rsp          div_rsp;

    logic [15:0]       effq;
    logic              fifo;
    logic [16:0]       lsum;
    logic [FCNT_W-1:0] nflows;
    logic [TIME_W:0]   tsum;
    logic              wfq_on;
    t_state            after_place;
    logic [FIDX_W-1:0] look_f;
    logic [15:0]       sv_len;

    fqps_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_pkt_ram (
        .i_clk   (i_clk),
        .i_we    (pkt_we),
        .i_waddr (r_p),
        .i_wdata ({r_tag, r_len}),
        .i_raddr (pkt_raddr),
        .o_rdata (pkt_rdata)
    );

    fqps_ram #(.WIDTH(SIDX_W), .DEPTH(SLOTS)) u_nxt_ram (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (nxt_waddr),
        .i_wdata (nxt_wdata),
        .i_raddr (nxt_raddr),
        .o_rdata (nxt_rdata)
    );

    fqps_ram #(.WIDTH(SIDX_W), .DEPTH(SLOTS)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (fl_we),
        .i_waddr (r_stk[SIDX_W-1:0]),
        .i_wdata (fl_wdata),
        .i_raddr (fl_raddr),
        .o_rdata (fl_rdata)
    );

    fqps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign effq        = (r_quantum < MIN_QUANT) ? DFLT_QUANT : r_quantum;
    assign fifo        = (r_mode == MODE_FIFO) || (r_mode == MODE_FIFO_ALT);
    assign lsum        = {1'b0, r_plen} + 17'(r_ovh);
    assign nflows      = r_nact + FCNT_W'(1);
    assign tsum        = {1'b0, r_now} + (TIME_W + 1)'(div_rsp.quo);
    assign wfq_on      = (r_mode == MODE_WFQ) && (r_rate != '0);
    assign after_place = r_svc ? S_EMIT : S_CHK;
    assign look_f      = r_ord[r_pos[FIDX_W-1:0]];
    assign sv_len      = pkt_rdata[15:0];

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    always_comb begin
        n_state   = r_state;
        n_nact    = r_nact;
        n_total   = r_total;
        n_stk     = r_stk;
        n_fresh   = r_fresh;
        n_cnt     = r_cnt;
        n_ovalid  = r_ovalid && !o_out.ready;
        n_sig     = r_sig;
        n_def     = r_def;
        n_fin     = r_fin;
        n_head    = r_head;
        n_tail    = r_tail;
        n_ord     = r_ord;
        n_out     = r_out;
        n_res     = r_res;
        n_tag     = r_tag;
        n_len     = r_len;
        n_isig    = r_isig;
        n_now     = r_now;
        n_svc     = r_svc;
        n_found   = r_found;
        n_pos     = r_pos;
        n_fi      = r_fi;
        n_f       = r_f;
        n_g       = r_g;
        n_longest = r_longest;
        n_p       = r_p;
        n_q       = r_q;
        n_d       = r_d;
        n_walk    = r_walk;
        n_plen    = r_plen;
        n_prod    = r_prod;
        pkt_we    = 1'b0;
        nxt_we    = 1'b0;
        fl_we     = 1'b0;
        pkt_raddr = r_d;
        nxt_raddr = r_q;
        nxt_waddr = r_tail[r_f];
        nxt_wdata = r_p;
        fl_raddr  = SIDX_W'(r_stk - QCNT_W'(1));
        fl_wdata  = r_d;
        div_req   = '{start: 1'b0, num: '0, den: r_rate};

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_tag   = i_in.data.pkt_tag;
                    n_len   = i_in.data.pkt_len;
                    n_now   = i_in.data.now_us;
                    n_svc   = (i_in.data.kind != KIND_ARRIVAL);
                    n_found = 1'b0;
                    n_pos   = '0;
                    n_fi    = '0;
                    n_isig  = (!fifo && i_in.data.ipv4_plain)
                            ? flow_hash(i_in.data.src_addr, i_in.data.dst_addr) : 32'd0;
                    if (i_in.data.kind == KIND_ARRIVAL) begin
                        n_state = S_LOOK;
                    end else if (r_nact == '0) begin
                        n_res   = '{result_kind: RES_NONE, out_tag: '0, out_len: '0,
                                    flow_sig: '0, queued_total: '0};
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_SV0;
                    end
                end
            end
            S_LOOK: begin
                if (r_pos < r_nact) begin
                    if (r_sig[look_f] == r_isig) begin
                        n_f     = look_f;
                        n_found = 1'b1;
                        n_state = S_ALLOC;
                    end else begin
                        n_pos = r_pos + FCNT_W'(1);
                    end
                end else if (r_nact == FCNT_W'(FLOWS)) begin
                    n_res   = '{result_kind: RES_FULL, out_tag: r_tag, out_len: r_len,
                                flow_sig: r_isig, queued_total: '0};
                    n_state = S_EMIT;
                end else begin
                    n_state = S_FREEF;
                end
            end
            S_FREEF: begin
                // Fewer than all flows are active, so an empty flow slot exists.
                if (r_cnt[r_fi] == '0) begin
                    n_f     = r_fi;
                    n_state = S_ALLOC;
                end else begin
                    n_fi = r_fi + FIDX_W'(1);
                end
            end
            S_ALLOC: begin
                if (r_total == QCNT_W'(SLOTS)) begin
                    n_res   = '{result_kind: RES_DROP, out_tag: r_tag, out_len: r_len,
                                flow_sig: r_isig, queued_total: '0};
                    n_state = S_EMIT;
                end else if (r_stk != '0) begin
                    n_stk   = r_stk - QCNT_W'(1);
                    n_state = S_POPW;
                end else begin
                    n_p     = r_fresh[SIDX_W-1:0];
                    n_fresh = r_fresh + QCNT_W'(1);
                    n_state = S_WRPKT;
                end
            end
            S_POPW: begin
                n_p     = fl_rdata;
                n_state = S_WRPKT;
            end
            S_WRPKT: begin
                pkt_we  = 1'b1;
                n_total = r_total + QCNT_W'(1);
                if (r_found) begin
                    nxt_we          = 1'b1;
                    n_tail[r_f]     = r_p;
                    n_cnt[r_f]      = r_cnt[r_f] + QCNT_W'(1);
                    n_state         = S_CHK;
                end else begin
                    n_sig[r_f]  = r_isig;
                    n_cnt[r_f]  = QCNT_W'(1);
                    n_head[r_f] = r_p;
                    n_tail[r_f] = r_p;
                    n_def[r_f]  = (r_mode == MODE_DRR) ? DEF_W'(effq) : '0;
                    n_fin[r_f]  = '0;
                    n_plen      = r_len;
                    n_state     = S_PLACE;
                end
            end
            S_PLACE: begin
                if (wfq_on) begin
                    n_state = S_MUL1;
                end else begin
                    n_ord   = ord_insert(r_ord, r_nact, r_f);
                    n_nact  = r_nact + FCNT_W'(1);
                    n_state = after_place;
                end
            end
            S_MUL1: begin
                n_prod  = PROD_W'(PROD_W'(lsum) * PROD_W'(nflows));
                n_state = S_MUL2;
            end
            S_MUL2: begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'((PROD_W + SCALE_W)'(r_prod)
                                       * (PROD_W + SCALE_W)'(BIT_SCALE));
                n_state       = S_DIVW;
            end
            S_DIVW: begin
                if (div_rsp.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_fin[r_f] = tsum[TIME_W] ? '1 : tsum[TIME_W-1:0];
                n_pos      = '0;
                n_state    = S_INS;
            end
            S_INS: begin
                // The new flow goes before the first one with a later finish time.
                if (r_pos < r_nact && !(r_fin[look_f] > r_fin[r_f])) begin
                    n_pos = r_pos + FCNT_W'(1);
                end else begin
                    n_ord   = ord_insert(r_ord, r_pos, r_f);
                    n_nact  = r_nact + FCNT_W'(1);
                    n_state = after_place;
                end
            end
            S_CHK: begin
                if (r_total > QCNT_W'(r_limit)) begin
                    n_longest = '0;
                    n_g       = r_f;
                    n_pos     = '0;
                    n_state   = S_LONG;
                end else begin
                    n_res   = '{result_kind: RES_ACC, out_tag: r_tag, out_len: r_len,
                                flow_sig: r_isig, queued_total: '0};
                    n_state = S_EMIT;
                end
            end
            S_LONG: begin
                if (r_pos < r_nact) begin
                    if (r_cnt[look_f] > r_longest) begin
                        n_longest = r_cnt[look_f];
                        n_g       = look_f;
                    end
                    n_pos = r_pos + FCNT_W'(1);
                end else if (r_drop_head || r_cnt[r_g] <= QCNT_W'(1)) begin
                    n_d       = r_head[r_g];
                    nxt_raddr = r_head[r_g];
                    n_state   = S_DHEAD;
                end else begin
                    n_q       = r_head[r_g];
                    n_walk    = '0;
                    nxt_raddr = r_head[r_g];
                    n_state   = S_WALK;
                end
            end
            S_DHEAD: begin
                n_head[r_g] = nxt_rdata;
                pkt_raddr   = r_d;
                n_state     = S_DROP;
            end
            S_WALK: begin
                // Find the packet just before the tail; the list has no back links.
                if (nxt_rdata != r_tail[r_g] && r_walk < WALK_W'(SLOTS)) begin
                    n_q       = nxt_rdata;
                    n_walk    = r_walk + WALK_W'(1);
                    nxt_raddr = nxt_rdata;
                end else begin
                    n_d         = r_tail[r_g];
                    n_tail[r_g] = r_q;
                    pkt_raddr   = r_tail[r_g];
                    n_state     = S_DROP;
                end
            end
            S_DROP: begin
                n_cnt[r_g] = r_cnt[r_g] - QCNT_W'(1);
                fl_we      = 1'b1;
                fl_wdata   = r_d;
                n_stk      = r_stk + QCNT_W'(1);
                n_total    = r_total - QCNT_W'(1);
                n_res      = '{result_kind: RES_DROP, out_tag: pkt_rdata[31:16],
                               out_len: pkt_rdata[15:0], flow_sig: r_sig[r_g],
                               queued_total: '0};
                if (r_cnt[r_g] == QCNT_W'(1)) begin
                    n_pos   = '0;
                    n_state = S_FIND;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_FIND: begin
                if (look_f == r_g) begin
                    n_ord   = ord_remove(r_ord, r_pos);
                    n_nact  = r_nact - FCNT_W'(1);
                    n_state = S_EMIT;
                end else begin
                    n_pos = r_pos + FCNT_W'(1);
                end
            end
            S_SV0: begin
                n_f       = r_ord[0];
                pkt_raddr = r_head[r_ord[0]];
                nxt_raddr = r_head[r_ord[0]];
                n_state   = S_SV1;
            end
            S_SV1: begin
                if (r_mode == MODE_DRR && DEF_W'(sv_len) > r_def[r_f]) begin
                    n_def[r_f] = r_def[r_f] + DEF_W'(effq);
                    n_ord      = ord_rotate(r_ord, r_nact);
                    n_state    = S_SV0;
                end else begin
                    if (r_mode == MODE_DRR) begin
                        n_def[r_f] = r_def[r_f] - DEF_W'(sv_len);
                    end
                    n_head[r_f] = nxt_rdata;
                    n_cnt[r_f]  = r_cnt[r_f] - QCNT_W'(1);
                    fl_we       = 1'b1;
                    fl_wdata    = r_head[r_f];
                    n_stk       = r_stk + QCNT_W'(1);
                    if (r_total != '0) begin
                        n_total = r_total - QCNT_W'(1);
                    end
                    n_res = '{result_kind: RES_FWD, out_tag: pkt_rdata[31:16],
                              out_len: sv_len, flow_sig: r_sig[r_f], queued_total: '0};
                    if (r_cnt[r_f] != QCNT_W'(1)) begin
                        if (r_mode == MODE_WFQ) begin
                            n_ord     = ord_remove(r_ord, '0);
                            n_nact    = r_nact - FCNT_W'(1);
                            pkt_raddr = nxt_rdata;
                            n_state   = S_SV3;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end else begin
                        n_ord   = ord_remove(r_ord, '0);
                        n_nact  = r_nact - FCNT_W'(1);
                        n_state = S_EMIT;
                    end
                end
            end
            S_SV3: begin
                n_plen  = sv_len;
                n_state = S_PLACE;
            end
            S_EMIT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_out              = r_res;
                    n_out.queued_total = r_total;
                    n_ovalid           = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nact      <= '0;
            r_total     <= '0;
            r_stk       <= '0;
            r_fresh     <= '0;
            r_cnt       <= '0;
            r_ovalid    <= 1'b0;
            r_mode      <= MODE_FIFO;
            r_quantum   <= DFLT_QUANT;
            r_limit     <= 6'd50;
            r_drop_head <= 1'b0;
            r_rate      <= '0;
            r_ovh       <= '0;
        end else begin
            r_state  <= n_state;
            r_nact   <= n_nact;
            r_total  <= n_total;
            r_stk    <= n_stk;
            r_fresh  <= n_fresh;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_MODE:    r_mode      <= i_cfg_wdata[1:0];
                    CFG_QUANTUM: r_quantum   <= i_cfg_wdata[15:0];
                    CFG_LIMIT:   r_limit     <= i_cfg_wdata[5:0];
                    CFG_DROPHD:  r_drop_head <= i_cfg_wdata[0];
                    CFG_RATE:    r_rate      <= i_cfg_wdata;
                    CFG_OVH:     r_ovh       <= i_cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sig     <= n_sig;
        r_def     <= n_def;
        r_fin     <= n_fin;
        r_head    <= n_head;
        r_tail    <= n_tail;
        r_ord     <= n_ord;
        r_out     <= n_out;
        r_res     <= n_res;
        r_tag     <= n_tag;
        r_len     <= n_len;
        r_isig    <= n_isig;
        r_now     <= n_now;
        r_svc     <= n_svc;
        r_found   <= n_found;
        r_pos     <= n_pos;
        r_fi      <= n_fi;
        r_f       <= n_f;
        r_g       <= n_g;
        r_longest <= n_longest;
        r_p       <= n_p;
        r_q       <= n_q;
        r_d       <= n_d;
        r_walk    <= n_walk;
        r_plen    <= n_plen;
        r_prod    <= n_prod;
    end
endmodule
